### src/fms_pkg.sv
package fms_pkg;

    // Flight mode codes
    localparam logic [1:0] MODE_GROUND    = 2'd0;
    localparam logic [1:0] MODE_MANUAL    = 2'd1;
    localparam logic [1:0] MODE_BASE      = 2'd2;
    localparam logic [1:0] MODE_PARACHUTE = 2'd3;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_RP_MAX    = 2'd0;
    localparam logic [1:0] REG_YAW_MAX   = 2'd1;
    localparam logic [1:0] REG_BATT_MIN  = 2'd2;
    localparam logic [1:0] REG_BATT_CHK  = 2'd3;

    // Pulse thresholds, microseconds
    localparam logic [11:0] PULSE_CENTER = 12'd1500;
    localparam logic [11:0] ARM_LEVEL    = 12'd1500;
    localparam logic [11:0] THR_ARM_LO   = 12'd1070;
    localparam logic [11:0] THR_ARM_HI   = 12'd1100;
    localparam logic [11:0] SW_HIGH      = 12'd1650;
    localparam logic [11:0] SW_MID       = 12'd1350;
    localparam logic [11:0] SW_LOW       = 12'd1000;
    localparam logic [12:0] THR_OFFSET   = 13'd1050;

    // x / 5 as (x * ceil(2^16 / 5)) >> 16, exact for x below 16384
    localparam logic [25:0] DIV5_MUL = 26'd13108;

    // Stick pulse taken apart as sign, |pulse - 1500| / 5 and remainder
    typedef struct packed {
        logic       neg;
        logic [9:0] quot;
        logic [2:0] rem;
    } stick_t;

    // floor(r * max / 5) for r = 1..4, entry r-1
    typedef logic [3:0][8:0] frac_tbl_t;

    function automatic logic [9:0] div5(input logic [11:0] x);
        logic [25:0] p;
        p = {14'd0, x} * DIV5_MUL;
        return p[25:16];
    endfunction

    function automatic stick_t stick_decode(input logic [11:0] pulse);
        logic signed [12:0] d;
        logic [11:0]        mag;
        logic [9:0]         q;
        logic [11:0]        q5;
        stick_t             s;
        d      = $signed({1'b0, pulse}) - $signed({1'b0, PULSE_CENTER});
        mag    = d[12] ? 12'(-d) : d[11:0];
        q      = div5(mag);
        q5     = {q, 2'b00} + {2'b00, q};
        s.neg  = d[12];
        s.quot = q;
        s.rem  = 3'(mag - q5);
        return s;
    endfunction

endpackage

### src/fms_scale.sv
module fms_scale (
    input  fms_pkg::stick_t    stick,
    input  logic [8:0]         max_val,
    input  fms_pkg::frac_tbl_t frac,
    output logic signed [15:0] setpoint
);
    import fms_pkg::*;

    logic [1:0]  rem_idx;
    logic [8:0]  frac_sel;
    logic [18:0] prod;
    logic [19:0] mag;

    // |d| * max / 5 = quot * max + floor(rem * max / 5)
    always_comb
    begin
        rem_idx  = 2'(stick.rem - 3'd1);
        frac_sel = (stick.rem == 3'd0) ? 9'd0 : frac[rem_idx];
        prod     = stick.quot * max_val;
        mag      = {1'b0, prod} + {11'd0, frac_sel};
        if (!stick.neg)
        begin
            setpoint = (mag > 20'd32767) ? 16'sh7FFF : $signed(mag[15:0]);
        end
        else
        begin
            setpoint = (mag > 20'd32768) ? 16'sh8000 : $signed(16'(-mag[15:0]));
        end
    end

endmodule

### src/flight_mode_supervisor_top.sv
// Channel  | handshake                    | word
// ---------+------------------------------+------------------------------------------
// input    | in_valid / in_stall          | six RC pulses, link, battery, base angles,
//          |                              | parachute busy flag
// result   | out_valid / out_stall        | mode, motors at min, four held setpoints
// config   | APB psel/penable/pwrite      | four registers at byte address 4*i
//
// One word per cycle sustained while the result side does not stall; input register, then result.
// The next mode and held setpoints are formed combinationally from the input register,
// and the mode step is the only feedback loop; the stick scaling is one 10x9 multiply per
// stick on that path.
// Reset (rst_n low, async) clears mode and setpoints to ground/zero and loads
// the register defaults. A stall on the result side holds the result word and
// the input register; the input side stalls only when both are full.
module flight_mode_supervisor_top (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [11:0]        roll_pulse,
    input  logic [11:0]        pitch_pulse,
    input  logic [11:0]        yaw_pulse,
    input  logic [11:0]        throttle_pulse,
    input  logic [11:0]        arm_switch_pulse,
    input  logic [11:0]        mode_switch_pulse,
    input  logic               link_ok,
    input  logic [15:0]        battery_mv,
    input  logic signed [15:0] base_roll,
    input  logic signed [15:0] base_pitch,
    input  logic               parachute_busy,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         flight_mode,
    output logic               motors_at_min,
    output logic signed [15:0] roll_setpoint,
    output logic signed [15:0] pitch_setpoint,
    output logic signed [15:0] yaw_setpoint,
    output logic signed [12:0] throttle_setpoint
);
    import fms_pkg::*;

    // register defaults: 30 deg and 180 deg/s, fractional tables r*max/5
    localparam frac_tbl_t RP_FRAC_RST  = '{9'd24, 9'd18, 9'd12, 9'd6};
    localparam frac_tbl_t YAW_FRAC_RST = '{9'd144, 9'd108, 9'd72, 9'd36};

    // ---------------- configuration registers ----------------
    logic [7:0]  rp_max_reg;
    logic [8:0]  yaw_max_reg;
    logic [15:0] batt_min_reg;
    logic        batt_chk_reg;
    frac_tbl_t   rp_frac_reg;
    frac_tbl_t   yaw_frac_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    // the fractional tables are refreshed together with their register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_max_reg   <= 8'd30;
            yaw_max_reg  <= 9'd180;
            batt_min_reg <= 16'd10800;
            batt_chk_reg <= 1'b1;
            rp_frac_reg  <= RP_FRAC_RST;
            yaw_frac_reg <= YAW_FRAC_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_RP_MAX:
                begin
                    rp_max_reg <= pwdata[7:0];
                    for (int k = 0; k < 4; k++)
                    begin
                        rp_frac_reg[k] <= 9'(div5({4'd0, pwdata[7:0]} * 12'(k + 1)));
                    end
                end
                REG_YAW_MAX:
                begin
                    yaw_max_reg <= pwdata[8:0];
                    for (int k = 0; k < 4; k++)
                    begin
                        yaw_frac_reg[k] <= 9'(div5({3'd0, pwdata[8:0]} * 12'(k + 1)));
                    end
                end
                REG_BATT_MIN: batt_min_reg <= pwdata[15:0];
                REG_BATT_CHK: batt_chk_reg <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RP_MAX:   prdata = {24'd0, rp_max_reg};
            REG_YAW_MAX:  prdata = {23'd0, yaw_max_reg};
            REG_BATT_MIN: prdata = {16'd0, batt_min_reg};
            REG_BATT_CHK: prdata = {31'd0, batt_chk_reg};
        endcase
    end

    // ---------------- handshake ----------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic in_accept;
    logic advance;

    assign advance   = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall  = s1_valid_reg & ~advance;
    assign in_accept = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;

    assign s1_valid_next  = in_accept | (s1_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- input register ----------------
    // sticks are pre-split into sign, /5 quotient and remainder on the way in
    stick_t             roll_st_reg;
    stick_t             pitch_st_reg;
    stick_t             yaw_st_reg;
    logic [11:0]        thr_reg;
    logic [11:0]        arm_reg;
    logic [11:0]        sw_reg;
    logic               link_reg;
    logic [15:0]        batt_reg;
    logic signed [15:0] broll_reg;
    logic signed [15:0] bpitch_reg;
    logic               busy_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            roll_st_reg  <= stick_decode(roll_pulse);
            pitch_st_reg <= stick_decode(pitch_pulse);
            yaw_st_reg   <= stick_decode(yaw_pulse);
            thr_reg      <= throttle_pulse;
            arm_reg      <= arm_switch_pulse;
            sw_reg       <= mode_switch_pulse;
            link_reg     <= link_ok;
            batt_reg     <= battery_mv;
            broll_reg    <= base_roll;
            bpitch_reg   <= base_pitch;
            busy_reg     <= parachute_busy;
        end
    end

    // ---------------- stick scaling ----------------
    logic signed [15:0] roll_scaled;
    logic signed [15:0] pitch_scaled;
    logic signed [15:0] yaw_scaled;

    fms_scale u_scale_roll (
        .stick    (roll_st_reg),
        .max_val  ({1'b0, rp_max_reg}),
        .frac     (rp_frac_reg),
        .setpoint (roll_scaled)
    );

    fms_scale u_scale_pitch (
        .stick    (pitch_st_reg),
        .max_val  ({1'b0, rp_max_reg}),
        .frac     (rp_frac_reg),
        .setpoint (pitch_scaled)
    );

    fms_scale u_scale_yaw (
        .stick    (yaw_st_reg),
        .max_val  (yaw_max_reg),
        .frac     (yaw_frac_reg),
        .setpoint (yaw_scaled)
    );

    // ---------------- mode step ----------------
    // mode and held setpoints double as the result register
    logic [1:0]         mode_reg;
    logic [1:0]         mode_next;
    logic               motors_reg;
    logic               motors_next;
    logic signed [15:0] roll_held_reg;
    logic signed [15:0] roll_held_next;
    logic signed [15:0] pitch_held_reg;
    logic signed [15:0] pitch_held_next;
    logic signed [15:0] yaw_held_reg;
    logic signed [15:0] yaw_held_next;
    logic signed [12:0] thr_held_reg;
    logic signed [12:0] thr_held_next;

    logic safety;
    logic arm_ok;
    logic batt_ok;
    logic thr_window;
    logic sw_above_high;
    logic sw_above_mid;
    logic sw_mid_band;
    logic sw_low_band;
    logic signed [12:0] thr_stick;

    always_comb
    begin
        safety        = (arm_reg < ARM_LEVEL) | (thr_reg < THR_ARM_LO) | ~link_reg;
        arm_ok        = (arm_reg > ARM_LEVEL) & link_reg;
        batt_ok       = (batt_reg > batt_min_reg) | ~batt_chk_reg;
        thr_window    = (thr_reg > THR_ARM_LO) & (thr_reg < THR_ARM_HI);
        sw_above_high = sw_reg > SW_HIGH;
        sw_above_mid  = sw_reg > SW_MID;
        sw_mid_band   = (sw_reg > SW_MID) & (sw_reg < SW_HIGH);
        sw_low_band   = (sw_reg > SW_LOW) & (sw_reg < SW_MID);
        thr_stick     = $signed({1'b0, thr_reg}) - $signed(THR_OFFSET);

        mode_next       = mode_reg;
        motors_next     = 1'b0;
        roll_held_next  = roll_held_reg;
        pitch_held_next = pitch_held_reg;
        yaw_held_next   = yaw_held_reg;
        thr_held_next   = thr_held_reg;

        unique case (mode_reg)
            MODE_GROUND:
            begin
                motors_next = 1'b1;
                if (arm_ok & batt_ok & thr_window)
                begin
                    mode_next = MODE_MANUAL;
                end
            end
            MODE_MANUAL:
            begin
                roll_held_next  = roll_scaled;
                pitch_held_next = pitch_scaled;
                yaw_held_next   = yaw_scaled;
                thr_held_next   = thr_stick;
                priority if (safety)        mode_next = MODE_GROUND;
                else if (sw_above_high)     mode_next = MODE_PARACHUTE;
                else if (sw_above_mid)      mode_next = MODE_BASE;
                else                        mode_next = MODE_MANUAL;
            end
            MODE_BASE:
            begin
                roll_held_next  = broll_reg;
                pitch_held_next = bpitch_reg;
                yaw_held_next   = yaw_scaled;
                thr_held_next   = thr_stick;
                priority if (safety)        mode_next = MODE_GROUND;
                else if (sw_above_high)     mode_next = MODE_PARACHUTE;
                else if (sw_low_band)       mode_next = MODE_MANUAL;
                else                        mode_next = MODE_BASE;
            end
            MODE_PARACHUTE:
            begin
                thr_held_next = thr_stick;
                // finished sequence drops to ground unless the switch says otherwise
                priority if (safety)        mode_next = MODE_GROUND;
                else if (sw_mid_band)       mode_next = MODE_BASE;
                else if (sw_low_band)       mode_next = MODE_MANUAL;
                else if (!busy_reg)         mode_next = MODE_GROUND;
                else                        mode_next = MODE_PARACHUTE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_GROUND;
            motors_reg     <= 1'b0;
            roll_held_reg  <= '0;
            pitch_held_reg <= '0;
            yaw_held_reg   <= '0;
            thr_held_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            motors_reg     <= motors_next;
            roll_held_reg  <= roll_held_next;
            pitch_held_reg <= pitch_held_next;
            yaw_held_reg   <= yaw_held_next;
            thr_held_reg   <= thr_held_next;
        end
    end

    assign flight_mode       = mode_reg;
    assign motors_at_min     = motors_reg;
    assign roll_setpoint     = roll_held_reg;
    assign pitch_setpoint    = pitch_held_reg;
    assign yaw_setpoint      = yaw_held_reg;
    assign throttle_setpoint = thr_held_reg;

    // ---------------- assertions ----------------
    a_motors_from_ground: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (motors_reg == ($past(mode_reg) == MODE_GROUND)))
        else $error("motors_at_min does not match the mode the step ran in");

    a_ground_exits_manual: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && mode_reg == MODE_GROUND)
        |=> (mode_reg == MODE_GROUND || mode_reg == MODE_MANUAL))
        else $error("ground mode left for something other than manual");

    a_ground_holds_setpoints: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && mode_reg == MODE_GROUND)
        |=> ($stable(roll_held_reg) && $stable(pitch_held_reg)
             && $stable(yaw_held_reg) && $stable(thr_held_reg)))
        else $error("setpoints changed during a ground step");

    a_parachute_holds_attitude: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && mode_reg == MODE_PARACHUTE)
        |=> ($stable(roll_held_reg) && $stable(pitch_held_reg) && $stable(yaw_held_reg)))
        else $error("attitude setpoints changed during a parachute step");

endmodule

### sim/flight_mode_checker.sv
`timescale 1ns / 100ps

module flight_mode_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [11:0]        roll_pulse,
    input  logic [11:0]        pitch_pulse,
    input  logic [11:0]        yaw_pulse,
    input  logic [11:0]        throttle_pulse,
    input  logic [11:0]        arm_switch_pulse,
    input  logic [11:0]        mode_switch_pulse,
    input  logic               link_ok,
    input  logic [15:0]        battery_mv,
    input  logic signed [15:0] base_roll,
    input  logic signed [15:0] base_pitch,
    input  logic               parachute_busy,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         flight_mode,
    input  logic               motors_at_min,
    input  logic signed [15:0] roll_setpoint,
    input  logic signed [15:0] pitch_setpoint,
    input  logic signed [15:0] yaw_setpoint,
    input  logic signed [12:0] throttle_setpoint,
    output int                 n_errors,
    output int                 n_waiting
);

    import fms_pkg::*;

    // thresholds, microseconds
    localparam int STICK_MID      = 1500;
    localparam int ARM_MID        = 1500;
    localparam int THROTTLE_FLOOR = 1070;
    localparam int THROTTLE_CEIL  = 1100;
    localparam int SWITCH_UPPER   = 1650;
    localparam int SWITCH_CENTER  = 1350;
    localparam int SWITCH_LOWER   = 1000;
    localparam int THROTTLE_ZERO  = 1050;

    typedef struct packed {
        logic [1:0]         mode;
        logic               motors;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [12:0] thr;
    } setpoint_word_t;

    setpoint_word_t     pending_setpoints[$];
    int                 err_count;

    // configuration copy
    logic [7:0]         rp_max;
    logic [8:0]         yaw_max;
    logic [15:0]        batt_min;
    logic               batt_chk;

    // mode and held setpoints
    logic [1:0]         mode_q;
    logic signed [15:0] roll_q;
    logic signed [15:0] pitch_q;
    logic signed [15:0] yaw_q;
    logic signed [12:0] thr_q;

    function automatic logic signed [15:0] scale_stick(input logic [11:0] pulse,
                                                       input logic [8:0] full);
        int prod;
        int q;
        prod = (int'(pulse) - STICK_MID) * int'(full);
        q    = prod / 5;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return 16'(q);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            REG_RP_MAX:   rp_max   = data[7:0];
            REG_YAW_MAX:  yaw_max  = data[8:0];
            REG_BATT_MIN: batt_min = data[15:0];
            REG_BATT_CHK: batt_chk = data[0];
            default: ;
        endcase
    endtask

    task automatic predict_tick();
        logic           safety;
        logic           motors;
        logic [11:0]    sw;
        setpoint_word_t w;
        sw     = mode_switch_pulse;
        safety = (arm_switch_pulse < ARM_MID) || (throttle_pulse < THROTTLE_FLOOR) || !link_ok;
        motors = 1'b0;
        case (mode_q)
            MODE_GROUND:
            begin
                motors = 1'b1;
                if (arm_switch_pulse > ARM_MID && link_ok &&
                    (battery_mv > batt_min || !batt_chk) &&
                    throttle_pulse < THROTTLE_CEIL && throttle_pulse > THROTTLE_FLOOR)
                    mode_q = MODE_MANUAL;
            end
            MODE_MANUAL:
            begin
                roll_q  = scale_stick(roll_pulse, {1'b0, rp_max});
                pitch_q = scale_stick(pitch_pulse, {1'b0, rp_max});
                yaw_q   = scale_stick(yaw_pulse, yaw_max);
                thr_q   = 13'(int'(throttle_pulse) - THROTTLE_ZERO);
                if (safety)
                    mode_q = MODE_GROUND;
                else if (sw > SWITCH_UPPER)
                    mode_q = MODE_PARACHUTE;
                else if (sw > SWITCH_CENTER)
                    mode_q = MODE_BASE;
            end
            MODE_BASE:
            begin
                yaw_q   = scale_stick(yaw_pulse, yaw_max);
                thr_q   = 13'(int'(throttle_pulse) - THROTTLE_ZERO);
                roll_q  = base_roll;
                pitch_q = base_pitch;
                if (safety)
                    mode_q = MODE_GROUND;
                else if (sw > SWITCH_UPPER)
                    mode_q = MODE_PARACHUTE;
                else if (sw < SWITCH_CENTER && sw > SWITCH_LOWER)
                    mode_q = MODE_MANUAL;
            end
            default:
            begin
                thr_q = 13'(int'(throttle_pulse) - THROTTLE_ZERO);
                // finished sequence lands on ground, a switch choice still wins
                if (!parachute_busy)
                    mode_q = MODE_GROUND;
                if (safety)
                    mode_q = MODE_GROUND;
                else if (sw > SWITCH_CENTER && sw < SWITCH_UPPER)
                    mode_q = MODE_BASE;
                else if (sw < SWITCH_CENTER && sw > SWITCH_LOWER)
                    mode_q = MODE_MANUAL;
            end
        endcase
        w.mode   = mode_q;
        w.motors = motors;
        w.roll   = roll_q;
        w.pitch  = pitch_q;
        w.yaw    = yaw_q;
        w.thr    = thr_q;
        pending_setpoints.push_back(w);
    endtask

    task automatic check_word();
        setpoint_word_t w;
        if (pending_setpoints.size() == 0)
        begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: result word with nothing expected: mode %0d motors %0d",
                         $time, flight_mode, motors_at_min);
        end
        else
        begin
            w = pending_setpoints.pop_front();
            if (w.mode !== flight_mode || w.motors !== motors_at_min ||
                w.roll !== roll_setpoint || w.pitch !== pitch_setpoint ||
                w.yaw !== yaw_setpoint || w.thr !== throttle_setpoint)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: mismatch exp mode %0d min %0d r %0d p %0d y %0d t %0d / got mode %0d min %0d r %0d p %0d y %0d t %0d",
                             $time, w.mode, w.motors, $signed(w.roll), $signed(w.pitch),
                             $signed(w.yaw), $signed(w.thr), flight_mode, motors_at_min,
                             roll_setpoint, pitch_setpoint, yaw_setpoint, throttle_setpoint);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_max    = 8'd30;
            yaw_max   = 9'd180;
            batt_min  = 16'd10800;
            batt_chk  = 1'b1;
            mode_q    = MODE_GROUND;
            roll_q    = '0;
            pitch_q   = '0;
            yaw_q     = '0;
            thr_q     = '0;
            err_count = 0;
            pending_setpoints.delete();
            n_errors  <= 0;
            n_waiting <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                write_reg(paddr[3:2], pwdata);
            if (in_valid && !in_stall)
                predict_tick();
            if (out_valid && !out_stall)
                check_word();
            n_errors  <= err_count;
            n_waiting <= pending_setpoints.size();
        end
    end

endmodule

### sim/flight_mode_supervisor_top_tb.sv
`timescale 1ns / 100ps

module flight_mode_supervisor_top_tb;

    import fms_pkg::*;

    // one control tick as driven on the input channel
    typedef struct packed {
        logic [11:0] roll;
        logic [11:0] pitch;
        logic [11:0] yaw;
        logic [11:0] thr;
        logic [11:0] arm;
        logic [11:0] sw;
        logic        link;
        logic [15:0] batt;
        logic [15:0] broll;
        logic [15:0] bpitch;
        logic        busy;
    } tick_t;

    localparam int SQUEEZE_CYCLES = 64;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [11:0]        roll_pulse;
    logic [11:0]        pitch_pulse;
    logic [11:0]        yaw_pulse;
    logic [11:0]        throttle_pulse;
    logic [11:0]        arm_switch_pulse;
    logic [11:0]        mode_switch_pulse;
    logic               link_ok;
    logic [15:0]        battery_mv;
    logic signed [15:0] base_roll;
    logic signed [15:0] base_pitch;
    logic               parachute_busy;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         flight_mode;
    logic               motors_at_min;
    logic signed [15:0] roll_setpoint;
    logic signed [15:0] pitch_setpoint;
    logic signed [15:0] yaw_setpoint;
    logic signed [12:0] throttle_setpoint;

    int                 n_errors;
    int                 n_waiting;

    // sender runs back to back while set
    bit                 no_gaps;
    // request for one long receiver hold-off; cleared by the stall process
    bit                 squeeze;
    // battery threshold currently programmed, steers the random battery values
    logic [15:0]        cur_batt_min;

    flight_mode_supervisor_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .roll_pulse        (roll_pulse),
        .pitch_pulse       (pitch_pulse),
        .yaw_pulse         (yaw_pulse),
        .throttle_pulse    (throttle_pulse),
        .arm_switch_pulse  (arm_switch_pulse),
        .mode_switch_pulse (mode_switch_pulse),
        .link_ok           (link_ok),
        .battery_mv        (battery_mv),
        .base_roll         (base_roll),
        .base_pitch        (base_pitch),
        .parachute_busy    (parachute_busy),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .flight_mode       (flight_mode),
        .motors_at_min     (motors_at_min),
        .roll_setpoint     (roll_setpoint),
        .pitch_setpoint    (pitch_setpoint),
        .yaw_setpoint      (yaw_setpoint),
        .throttle_setpoint (throttle_setpoint)
    );

    // predicts every accepted word and scores the result channel
    flight_mode_checker u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .pready            (pready),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .roll_pulse        (roll_pulse),
        .pitch_pulse       (pitch_pulse),
        .yaw_pulse         (yaw_pulse),
        .throttle_pulse    (throttle_pulse),
        .arm_switch_pulse  (arm_switch_pulse),
        .mode_switch_pulse (mode_switch_pulse),
        .link_ok           (link_ok),
        .battery_mv        (battery_mv),
        .base_roll         (base_roll),
        .base_pitch        (base_pitch),
        .parachute_busy    (parachute_busy),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .flight_mode       (flight_mode),
        .motors_at_min     (motors_at_min),
        .roll_setpoint     (roll_setpoint),
        .pitch_setpoint    (pitch_setpoint),
        .yaw_setpoint      (yaw_setpoint),
        .throttle_setpoint (throttle_setpoint),
        .n_errors          (n_errors),
        .n_waiting         (n_waiting)
    );

    // 12 ns clock
    initial
        clk = 1'b0;
    always #6 clk = ~clk;

    // hard stop far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // directed word: sticks share one pulse, pitch angle is the complement of roll
    function automatic tick_t tick(input logic [11:0] arm, input logic [11:0] thr,
                                   input logic [11:0] sw, input logic link,
                                   input logic [15:0] batt, input logic busy,
                                   input logic [11:0] stick, input logic [15:0] base);
        tick_t t;
        t.roll   = stick;
        t.pitch  = stick;
        t.yaw    = stick;
        t.thr    = thr;
        t.arm    = arm;
        t.sw     = sw;
        t.link   = link;
        t.batt   = batt;
        t.broll  = base;
        t.bpitch = ~base;
        t.busy   = busy;
        return t;
    endfunction

    // mode switch: mostly the decision boundaries, rest anywhere near the servo range
    function automatic logic [11:0] pick_switch();
        case ($urandom_range(0, 13))
            0:       return 12'd1000;
            1:       return 12'd1001;
            2:       return 12'd1349;
            3:       return 12'd1350;
            4:       return 12'd1351;
            5:       return 12'd1649;
            6:       return 12'd1650;
            7:       return 12'd1651;
            default: return 12'($urandom_range(900, 2100));
        endcase
    endfunction

    // Mostly plausible flight traffic so the arm sequence and mode changes get exercised;
    // about one word in ten is full-range noise on every field.
    function automatic tick_t random_tick();
        tick_t t;
        int    r;
        t.broll  = 16'($urandom);
        t.bpitch = 16'($urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            t.roll  = 12'($urandom);
            t.pitch = 12'($urandom);
            t.yaw   = 12'($urandom);
            t.thr   = 12'($urandom);
            t.arm   = 12'($urandom);
            t.sw    = 12'($urandom);
            t.link  = 1'($urandom);
            t.batt  = 16'($urandom);
            t.busy  = 1'($urandom);
            return t;
        end
        // sticks, occasionally far out to hit saturation
        if ($urandom_range(0, 6) == 0)
        begin
            t.roll  = 12'($urandom);
            t.pitch = 12'($urandom);
            t.yaw   = 12'($urandom);
        end
        else
        begin
            t.roll  = 12'($urandom_range(900, 2100));
            t.pitch = 12'($urandom_range(900, 2100));
            t.yaw   = 12'($urandom_range(900, 2100));
        end
        r = $urandom_range(0, 99);
        if (r < 8)
            t.arm = 12'd1500;
        else if (r < 15)
            t.arm = 12'($urandom_range(0, 1499));
        else
            t.arm = 12'($urandom_range(1501, 2100));
        t.link = ($urandom_range(0, 19) != 0);
        r = $urandom_range(0, 99);
        if (r < 35)
            t.thr = 12'($urandom_range(1071, 1099));
        else if (r < 45)
        begin
            case ($urandom_range(0, 3))
                0:       t.thr = 12'd1069;
                1:       t.thr = 12'd1070;
                2:       t.thr = 12'd1099;
                default: t.thr = 12'd1100;
            endcase
        end
        else
            t.thr = 12'($urandom_range(1000, 2000));
        t.sw = pick_switch();
        r = $urandom_range(0, 99);
        if (r < 60)
            t.batt = cur_batt_min + 16'($urandom_range(1, 3000));
        else if (r < 75)
            t.batt = cur_batt_min;
        else
            t.batt = 16'($urandom);
        t.busy = ($urandom_range(0, 4) < 3);
        return t;
    endfunction

    // sender gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one word and hold it until the edge that takes it. Called right after
    // an edge; returns at the accepting edge with in_valid still high, so a
    // back-to-back word costs a single assignment to in_valid in that step.
    task automatic send_tick(input tick_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        roll_pulse        <= t.roll;
        pitch_pulse       <= t.pitch;
        yaw_pulse         <= t.yaw;
        throttle_pulse    <= t.thr;
        arm_switch_pulse  <= t.arm;
        mode_switch_pulse <= t.sw;
        link_ok           <= t.link;
        battery_mv        <= t.batt;
        base_roll         <= t.broll;
        base_pitch        <= t.bpitch;
        parachute_busy    <= t.busy;
        in_valid          <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // setup then access cycle; psel drops after so writes never overlap
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // junk above the register width checks that only the low bits are kept
    task automatic set_config(input int rp, input int yaw, input int batt, input int chk,
                              input bit junk);
        logic [31:0] hi;
        hi = junk ? 32'($urandom) : 32'd0;
        apb_write(REG_RP_MAX,   {hi[31:8],  8'(rp)});
        apb_write(REG_YAW_MAX,  {hi[31:9],  9'(yaw)});
        apb_write(REG_BATT_MIN, {hi[31:16], 16'(batt)});
        apb_write(REG_BATT_CHK, {hi[31:1],  1'(chk)});
        cur_batt_min = 16'(batt);
    endtask

    // drain: every expected word back, then let the two-stage pipe settle
    task automatic settle();
        @(posedge clk);
        while (n_waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Walk the mode machine through every transition with reset config
    // (30 deg, 180 deg/s, 10800 mV, battery test on).
    task automatic run_directed();
        send_tick(tick(12'd0,    12'd0,    12'd0,    1'b0, 16'd0,     1'b0, 12'd0,    16'd0));
        // arm exactly at center neither arms nor trips safety
        send_tick(tick(12'd1500, 12'd1080, 12'd1500, 1'b1, 16'd12000, 1'b1, 12'd1500, 16'd0));
        // throttle window is open on both ends
        send_tick(tick(12'd1501, 12'd1070, 12'd1500, 1'b1, 16'd12000, 1'b1, 12'd1500, 16'd0));
        send_tick(tick(12'd1501, 12'd1100, 12'd1500, 1'b1, 16'd12000, 1'b1, 12'd1500, 16'd0));
        // battery must exceed the threshold
        send_tick(tick(12'd1501, 12'd1080, 12'd1500, 1'b1, 16'd10800, 1'b1, 12'd1500, 16'd0));
        send_tick(tick(12'd1501, 12'd1080, 12'd1500, 1'b0, 16'd12000, 1'b1, 12'd1500, 16'd0));
        // arms: ground -> manual
        send_tick(tick(12'd1501, 12'd1071, 12'd1500, 1'b1, 16'd10801, 1'b1, 12'd1500, 16'd0));
        // manual with full stick, switch to base
        send_tick(tick(12'd1600, 12'd1500, 12'd1500, 1'b1, 16'd12000, 1'b1, 12'd4095,
                       16'h8000));
        // base, switch on the 1350 boundary keeps base
        send_tick(tick(12'd1600, 12'd1500, 12'd1350, 1'b1, 16'd12000, 1'b1, 12'd1500,
                       16'h8000));
        send_tick(tick(12'd1600, 12'd1500, 12'd1001, 1'b1, 16'd12000, 1'b1, 12'd1500,
                       16'h7fff));
        // manual, zero stick, arm at center is not safety; to parachute
        send_tick(tick(12'd1500, 12'd2000, 12'd1651, 1'b1, 16'd12000, 1'b1, 12'd0,    16'd0));
        // parachute busy, switch matches no rule
        send_tick(tick(12'd1600, 12'd1500, 12'd1650, 1'b1, 16'd12000, 1'b1, 12'd1500, 16'd0));
        // sequence done, no switch choice: ground
        send_tick(tick(12'd1600, 12'd1500, 12'd1000, 1'b1, 16'd12000, 1'b0, 12'd1500, 16'd0));
        send_tick(tick(12'd4095, 12'd1099, 12'd1500, 1'b1, 16'd65535, 1'b1, 12'd1500, 16'd0));
        // manual, throttle at 1070 is not safety, switch at 1350 keeps manual
        send_tick(tick(12'd1600, 12'd1070, 12'd1350, 1'b1, 16'd12000, 1'b1, 12'd2000, 16'd0));
        send_tick(tick(12'd1600, 12'd1500, 12'd1700, 1'b1, 16'd12000, 1'b1, 12'd1500, 16'd0));
        // sequence done but switch picks base
        send_tick(tick(12'd1600, 12'd1500, 12'd1500, 1'b1, 16'd12000, 1'b0, 12'd1500, 16'd0));
        send_tick(tick(12'd1600, 12'd1500, 12'd1700, 1'b1, 16'd12000, 1'b1, 12'd1500, 16'd0));
        send_tick(tick(12'd1600, 12'd1500, 12'd1200, 1'b1, 16'd12000, 1'b1, 12'd1500, 16'd0));
        // manual, low throttle: ground
        send_tick(tick(12'd1600, 12'd1069, 12'd1200, 1'b1, 16'd12000, 1'b1, 12'd1800, 16'd0));
        send_tick(tick(12'd1501, 12'd1098, 12'd1200, 1'b1, 16'd11000, 1'b1, 12'd1500, 16'd0));
        send_tick(tick(12'd1600, 12'd1500, 12'd1400, 1'b1, 16'd11000, 1'b1, 12'd1300, 16'd0));
        // base, link lost: ground
        send_tick(tick(12'd1600, 12'd1500, 12'd1400, 1'b0, 16'd11000, 1'b1, 12'd1500,
                       16'h1234));
    endtask

    // Receiver: random stall and free stretches, plus one long hold-off on request
    // while the sender keeps pushing, which fills the block and backs up in_stall.
    initial
    begin
        int r;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (squeeze)
            begin
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(posedge clk);
                end
                else if (r < 85)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else if (r < 95)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(4, 12)) @(posedge clk);
                end
                else
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                end
            end
        end
    end

    // Stimulus: reset, then seven config phases, each drained before the next
    // register write. Phase 0 runs on reset defaults with the directed words.
    initial
    begin
        int ph;
        int i;
        int n_words;
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_valid          <= 1'b0;
        roll_pulse        <= '0;
        pitch_pulse       <= '0;
        yaw_pulse         <= '0;
        throttle_pulse    <= '0;
        arm_switch_pulse  <= '0;
        mode_switch_pulse <= '0;
        link_ok           <= 1'b0;
        battery_mv        <= '0;
        base_roll         <= '0;
        base_pitch        <= '0;
        parachute_busy    <= 1'b0;
        no_gaps           = 1'b0;
        squeeze           = 1'b0;
        cur_batt_min      = 16'd10800;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:       n_words = 350;
                1:       n_words = 300;
                2:       n_words = 200;
                3:       n_words = 300;
                4:       n_words = 260;
                5:       n_words = 280;
                default: n_words = 260;
            endcase
            case (ph)
                0: ;
                // everything at zero, battery test off
                1: set_config(0, 0, 0, 0, 1'b0);
                // every register at the top of its width
                2: set_config(255, 511, 65535, 1, 1'b0);
                // top of the stated ranges, battery test off
                3: set_config(180, 300, 65535, 0, 1'b0);
                default:
                    set_config($urandom_range(0, 255), $urandom_range(0, 511),
                               $urandom_range(9000, 13000), $urandom_range(0, 1), 1'b1);
            endcase
            if (ph == 0)
                run_directed();
            no_gaps = (ph == 1) || (ph == 5);
            if (ph == 5)
                squeeze = 1'b1;
            for (i = 0; i < n_words; i++)
            begin
                // back-to-back only for the first part of the pressure phase
                if (ph == 5 && i == 120)
                    no_gaps = 1'b0;
                send_tick(random_tick());
            end
            in_valid <= 1'b0;
            settle();
        end

        repeat (8) @(posedge clk);
        if (n_errors == 0 && n_waiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
